// ===== sv/dltq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dltq_pkg
// Types, codes and defaults shared by the delta-list timer queue modules.
// ----------------------------------------------------------------------------
package dltq_pkg;

    localparam int MAX_TIMERS_DEF = 16;
    localparam int TIME_BITS_DEF  = 24;

    localparam logic [1:0] ACT_ADD        = 2'd0;
    localparam logic [1:0] ACT_REMOVE     = 2'd1;
    localparam logic [1:0] ACT_REMOVE_ALL = 2'd2;
    localparam logic [1:0] ACT_TICK       = 2'd3;

    localparam logic [1:0] KIND_ADD_ACK    = 2'd0;
    localparam logic [1:0] KIND_REMOVE_ACK = 2'd1;
    localparam logic [1:0] KIND_EXPIRY     = 2'd2;
    localparam logic [1:0] KIND_NEXT       = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  owner_id;
        logic [15:0] user_tag;
        logic [23:0] timeout_ms;
        logic        periodic;
        logic        use_slot;
        logic [3:0]  slot_in;
        logic [23:0] elapsed_ms;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [3:0]  slot_out;
        logic [7:0]  owner_out;
        logic [15:0] tag_out;
        logic [23:0] next_timeout_ms;
        logic        queue_empty;
        logic        last;
    } rsp_t;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_REMOVE_SLOT,
        OP_REMOVE_OWNER,
        OP_REMOVE_ALL,
        OP_TICK
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  owner;
        logic [15:0] tag;
        logic [23:0] time_ms;
        logic        periodic;
        logic [3:0]  slot;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_WALK,
        ST_RM_WALK,
        ST_RMALL_WALK,
        ST_TICK_SUB,
        ST_TICK_CNT,
        ST_TICK_EXP,
        ST_RESP
    } eng_state_t;

endpackage

// ===== sv/delta_list_timer_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_list_timer_queue
// Timer queue kept as a delta-ordered list with add, remove and tick.
// ----------------------------------------------------------------------------
// Requests arrive on req (valid/ready) and results leave on rsp (valid/ready).
// Every request gives one or more results; the final one has last set.
// A two-entry command queue sits behind req, so up to two requests are taken
// while the list engine is busy; req_ready drops only when that queue is full.
// The engine handles one command at a time, walking one list entry a cycle:
// add walks to its position and inserts; remove and remove-all walk at most
// the n live timers. A tick walks the list to subtract time, counts the m
// expired head entries, then pops one expiry a cycle while the output is free;
// each periodic expiry is reinserted by a walk before the next one is popped.
// Results sit in one output register; while a result waits with rsp_ready low
// the engine holds before emitting its next result, and request transfers
// continue until the command queue fills. Reset empties the list and the
// command queue and drops rsp_valid.
module delta_list_timer_queue
    import dltq_pkg::*;
#(
    parameter int MAX_TIMERS = MAX_TIMERS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    dltq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    dltq_engine #(
        .MAX_TIMERS (MAX_TIMERS),
        .TIME_BITS  (TIME_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// ===== sv/dltq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dltq_front
// Accepts requests, decodes them into commands and queues two of them.
// ----------------------------------------------------------------------------
module dltq_front
    import dltq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic cmd_valid,
    input  logic cmd_ready,
    output cmd_t cmd
);

    cmd_t       q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    cmd_t       dec;
    logic       push;
    logic       pop;

    always_comb
    begin
        dec          = '0;
        dec.owner    = req.owner_id;
        dec.tag      = req.user_tag;
        dec.periodic = req.periodic;
        dec.slot     = req.slot_in;
        dec.time_ms  = req.timeout_ms;
        unique case (req.action)
            ACT_ADD:        dec.op = OP_ADD;
            ACT_REMOVE:     dec.op = req.use_slot ? OP_REMOVE_SLOT : OP_REMOVE_OWNER;
            ACT_REMOVE_ALL: dec.op = OP_REMOVE_ALL;
            default:
            begin
                dec.op      = OP_TICK;
                dec.time_ms = req.elapsed_ms;
            end
        endcase
    end

    assign req_ready = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_reg];
    assign push      = req_valid && req_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= dec;
        end
    end

endmodule

// ===== sv/dltq_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dltq_engine
// Walks and edits the delta-ordered list, one entry a cycle, and drives the
// registered result output.
// ----------------------------------------------------------------------------
module dltq_engine
    import dltq_pkg::*;
#(
    parameter int MAX_TIMERS = MAX_TIMERS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int IDX_W = $clog2(MAX_TIMERS);
    localparam int CW    = $clog2(MAX_TIMERS + 1);
    localparam int TW    = TIME_BITS;
    localparam int SW    = IDX_W + 4;

    typedef struct packed {
        logic [IDX_W-1:0] slot;
        logic [7:0]       owner;
        logic [15:0]      tag;
        logic [TW-1:0]    period;
        logic             periodic;
        logic [TW-1:0]    delta;
    } rec_t;

    eng_state_t          state_reg, state_next;
    rec_t                rec_reg [MAX_TIMERS];
    rec_t                rec_next [MAX_TIMERS];
    logic [MAX_TIMERS-1:0] used_reg, used_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [TW-1:0]       rest_reg, rest_next;
    rec_t                ins_reg, ins_next;
    logic                any_reg, any_next;
    logic                ret_add_reg, ret_add_next;
    cmd_t                cmd_reg, cmd_next;
    rsp_t                pend_reg, pend_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;

    rec_t                cur;
    rec_t                head;
    logic                idx_lt_n;
    logic                out_free;
    logic [IDX_W-1:0]    free_slot;
    logic                slot_ok;
    logic                own_eq;
    logic                slot_eq;
    logic                match;
    logic                do_take;
    logic [CW-1:0]       take_pos;
    logic                do_ins;
    rec_t                ins_rec;
    logic                do_dset;
    logic [TW-1:0]       dset_val;
    logic                emit;
    rsp_t                emit_val;

    function automatic rsp_t mk_rsp(logic [1:0] k, logic [1:0] st, logic [3:0] sl, logic ls);
        rsp_t r;
        r          = '0;
        r.kind     = k;
        r.status   = st;
        r.slot_out = sl;
        r.last     = ls;
        return r;
    endfunction

    assign cur      = rec_reg[idx_reg[IDX_W-1:0]];
    assign head     = rec_reg[0];
    assign idx_lt_n = (idx_reg < n_reg);
    assign out_free = !rsp_valid_reg || rsp_ready;
    assign own_eq   = (cur.owner == cmd_reg.owner);
    assign slot_eq  = (SW'(cur.slot) == SW'(cmd_reg.slot));
    assign match    = (cmd_reg.op == OP_REMOVE_SLOT) ? slot_eq : own_eq;
    assign slot_ok  = (SW'(cmd.slot) < SW'(MAX_TIMERS)) && used_reg[IDX_W'(cmd.slot)];

    always_comb
    begin
        free_slot = '0;
        for (int j = MAX_TIMERS - 1; j >= 0; j--)
        begin
            if (!used_reg[j])
            begin
                free_slot = IDX_W'(j);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        OP_ADD:
                            state_next = (n_reg == CW'(MAX_TIMERS)) ? ST_RESP : ST_INS_WALK;
                        OP_REMOVE_SLOT:
                            state_next = slot_ok ? ST_RM_WALK : ST_RESP;
                        OP_REMOVE_OWNER: state_next = ST_RM_WALK;
                        OP_REMOVE_ALL:   state_next = ST_RMALL_WALK;
                        default:         state_next = ST_TICK_SUB;
                    endcase
                end
            end
            ST_INS_WALK:
            begin
                if (!(idx_lt_n && rest_reg >= cur.delta))
                begin
                    state_next = ret_add_reg ? ST_RESP : ST_TICK_EXP;
                end
            end
            ST_RM_WALK:
            begin
                if (!idx_lt_n || match)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RMALL_WALK:
            begin
                if (!idx_lt_n)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_TICK_SUB:
            begin
                if (rest_reg == '0 || !idx_lt_n || cur.delta > rest_reg)
                begin
                    state_next = ST_TICK_CNT;
                end
            end
            ST_TICK_CNT:
            begin
                if (!(idx_lt_n && cur.delta == '0))
                begin
                    state_next = ST_TICK_EXP;
                end
            end
            ST_TICK_EXP:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_RESP;
                end
                else if (out_free && head.periodic)
                begin
                    state_next = ST_INS_WALK;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and list edits
    always_comb
    begin
        n_next       = n_reg;
        used_next    = used_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        rest_next    = rest_reg;
        ins_next     = ins_reg;
        any_next     = any_reg;
        ret_add_next = ret_add_reg;
        cmd_next     = cmd_reg;
        pend_next    = pend_reg;
        cmd_ready    = 1'b0;
        do_take      = 1'b0;
        take_pos     = idx_reg;
        do_ins       = 1'b0;
        ins_rec      = ins_reg;
        do_dset      = 1'b0;
        dset_val     = '0;
        emit         = 1'b0;
        emit_val     = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next = cmd;
                    idx_next = '0;
                    any_next = 1'b0;
                    unique case (cmd.op)
                        OP_ADD:
                        begin
                            if (n_reg == CW'(MAX_TIMERS))
                            begin
                                pend_next = mk_rsp(KIND_ADD_ACK, STAT_FULL, 4'd0, 1'b1);
                            end
                            else
                            begin
                                used_next[free_slot] = 1'b1;
                                ins_next.slot        = free_slot;
                                ins_next.owner       = cmd.owner;
                                ins_next.tag         = cmd.tag;
                                ins_next.period      = TW'(cmd.time_ms);
                                ins_next.periodic    = cmd.periodic;
                                ins_next.delta       = '0;
                                rest_next            = TW'(cmd.time_ms);
                                ret_add_next         = 1'b1;
                            end
                        end
                        OP_REMOVE_SLOT:
                        begin
                            pend_next = mk_rsp(KIND_REMOVE_ACK, STAT_NOT_FOUND, 4'd0, 1'b1);
                        end
                        OP_REMOVE_OWNER, OP_REMOVE_ALL:
                        begin
                        end
                        default:
                        begin
                            rest_next = TW'(cmd.time_ms);
                        end
                    endcase
                end
            end
            ST_INS_WALK:
            begin
                if (idx_lt_n && rest_reg >= cur.delta)
                begin
                    rest_next = rest_reg - cur.delta;
                    idx_next  = idx_reg + 1'b1;
                end
                else
                begin
                    do_ins        = 1'b1;
                    ins_rec.delta = rest_reg;
                    n_next        = n_reg + 1'b1;
                    pend_next     = mk_rsp(KIND_ADD_ACK, STAT_OK, 4'(ins_reg.slot), 1'b1);
                end
            end
            ST_RM_WALK:
            begin
                if (!idx_lt_n || (match && !own_eq))
                begin
                    pend_next = mk_rsp(KIND_REMOVE_ACK, STAT_NOT_FOUND, 4'd0, 1'b1);
                end
                else if (match)
                begin
                    do_take             = 1'b1;
                    n_next              = n_reg - 1'b1;
                    used_next[cur.slot] = 1'b0;
                    pend_next = mk_rsp(KIND_REMOVE_ACK, STAT_OK, 4'(cur.slot), 1'b1);
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_RMALL_WALK:
            begin
                if (!idx_lt_n)
                begin
                    pend_next = mk_rsp(KIND_REMOVE_ACK, any_reg ? STAT_OK : STAT_NOT_FOUND,
                                       4'd0, 1'b1);
                end
                else if (own_eq)
                begin
                    do_take             = 1'b1;
                    n_next              = n_reg - 1'b1;
                    used_next[cur.slot] = 1'b0;
                    any_next            = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_TICK_SUB:
            begin
                if (rest_reg == '0 || !idx_lt_n)
                begin
                    idx_next = '0;
                end
                else if (cur.delta > rest_reg)
                begin
                    do_dset  = 1'b1;
                    dset_val = cur.delta - rest_reg;
                    idx_next = '0;
                end
                else
                begin
                    do_dset   = 1'b1;
                    dset_val  = '0;
                    rest_next = rest_reg - cur.delta;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            ST_TICK_CNT:
            begin
                if (idx_lt_n && cur.delta == '0)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    cnt_next = idx_reg;
                end
            end
            ST_TICK_EXP:
            begin
                if (cnt_reg == '0)
                begin
                    pend_next = mk_rsp(KIND_NEXT, STAT_OK, 4'd0, 1'b1);
                    if (n_reg == '0)
                    begin
                        pend_next.queue_empty = 1'b1;
                    end
                    else
                    begin
                        pend_next.next_timeout_ms = 24'(head.delta);
                    end
                end
                else if (out_free)
                begin
                    emit               = 1'b1;
                    emit_val           = mk_rsp(KIND_EXPIRY, STAT_OK, 4'(head.slot), 1'b0);
                    emit_val.owner_out = head.owner;
                    emit_val.tag_out   = head.tag;
                    do_take            = 1'b1;
                    take_pos           = '0;
                    n_next             = n_reg - 1'b1;
                    cnt_next           = cnt_reg - 1'b1;
                    if (head.periodic)
                    begin
                        ins_next     = head;
                        rest_next    = head.period;
                        idx_next     = '0;
                        ret_add_next = 1'b0;
                    end
                    else
                    begin
                        used_next[head.slot] = 1'b0;
                    end
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    emit     = 1'b1;
                    emit_val = pend_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // list lanes: remove shifts left, insert shifts right
    always_comb
    begin
        rec_next = rec_reg;
        for (int j = 0; j < MAX_TIMERS; j++)
        begin
            if (do_take && CW'(j) >= take_pos)
            begin
                rec_next[j] = rec_reg[(j + 1 < MAX_TIMERS) ? j + 1 : j];
                if (CW'(j) == take_pos)
                begin
                    rec_next[j].delta = rec_reg[(j + 1 < MAX_TIMERS) ? j + 1 : j].delta
                                        + rec_reg[j].delta;
                end
            end
            else if (do_ins && CW'(j) > idx_reg)
            begin
                rec_next[j] = rec_reg[(j > 0) ? j - 1 : 0];
                if (CW'(j) == idx_reg + 1'b1)
                begin
                    rec_next[j].delta = rec_reg[(j > 0) ? j - 1 : 0].delta - ins_rec.delta;
                end
            end
            else if (do_ins && CW'(j) == idx_reg)
            begin
                rec_next[j] = ins_rec;
            end
            if (do_dset && CW'(j) == idx_reg)
            begin
                rec_next[j].delta = dset_val;
            end
        end
    end

    always_comb
    begin
        rsp_next       = emit ? emit_val : rsp_reg;
        rsp_valid_next = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_reg);
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            n_reg         <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            any_reg       <= 1'b0;
            ret_add_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            any_reg       <= any_next;
            ret_add_reg   <= ret_add_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg  <= rec_next;
        rest_reg <= rest_next;
        ins_reg  <= ins_next;
        cmd_reg  <= cmd_next;
        pend_reg <= pend_next;
        rsp_reg  <= rsp_next;
    end

endmodule

// ===== sim/delta_list_timer_queue_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_list_timer_queue_checker
// Watches the request and result channels of the timer queue, keeps its own
// copy of the delta list, works out the results of every accepted request
// and compares each result transfer field by field with the oldest one due.
// ----------------------------------------------------------------------------
module delta_list_timer_queue_checker
    import dltq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   errors,
    output int   pending,
    output int   expiries
);
    localparam int NT = MAX_TIMERS_DEF;

    logic        t_valid [NT];
    logic [7:0]  t_owner [NT];
    logic [15:0] t_tag [NT];
    logic [23:0] t_period [NT];
    logic        t_periodic [NT];
    logic [23:0] t_delta [NT];
    int          order [$];
    rsp_t        due_results [$];

    function automatic rsp_t blank();
        rsp_t r;
        r = '0;
        return r;
    endfunction

    // drop the entry at pos, folding its delay into the follower
    function automatic void take_at(int pos);
        if (pos + 1 < order.size())
            t_delta[order[pos + 1]] = t_delta[order[pos + 1]] + t_delta[order[pos]];
        order.delete(pos);
    endfunction

    // insert after all entries expiring at the same time
    function automatic void put_slot(int s);
        logic [23:0] rest;
        int i;
        rest = t_period[s];
        i = 0;
        while (i < order.size() && rest >= t_delta[order[i]])
        begin
            rest -= t_delta[order[i]];
            i++;
        end
        order.insert(i, s);
        t_delta[s] = rest;
        if (i + 1 < order.size())
            t_delta[order[i + 1]] = t_delta[order[i + 1]] - rest;
    endfunction

    function automatic void predict_request(req_t q);
        rsp_t r;
        int pos;
        int s;
        bit any;
        logic [23:0] e;
        int expired [$];
        r = blank();
        r.last = 1'b1;
        case (q.action)
            ACT_ADD:
            begin
                s = -1;
                for (int i = 0; i < NT; i++)
                    if (s < 0 && !t_valid[i])
                        s = i;
                r.kind = KIND_ADD_ACK;
                if (s < 0)
                    r.status = STAT_FULL;
                else
                begin
                    t_valid[s] = 1'b1;
                    t_owner[s] = q.owner_id;
                    t_tag[s] = q.user_tag;
                    t_period[s] = q.timeout_ms;
                    t_periodic[s] = q.periodic;
                    put_slot(s);
                    r.status = STAT_OK;
                    r.slot_out = 4'(s);
                end
                due_results.push_back(r);
            end
            ACT_REMOVE:
            begin
                pos = -1;
                if (q.use_slot)
                begin
                    if (t_valid[q.slot_in] && t_owner[q.slot_in] == q.owner_id)
                        foreach (order[i])
                            if (order[i] == q.slot_in)
                                pos = i;
                end
                else
                    foreach (order[i])
                        if (pos < 0 && t_owner[order[i]] == q.owner_id)
                            pos = i;
                r.kind = KIND_REMOVE_ACK;
                if (pos < 0)
                    r.status = STAT_NOT_FOUND;
                else
                begin
                    s = order[pos];
                    t_valid[s] = 1'b0;
                    take_at(pos);
                    r.status = STAT_OK;
                    r.slot_out = 4'(s);
                end
                due_results.push_back(r);
            end
            ACT_REMOVE_ALL:
            begin
                any = 0;
                pos = 0;
                while (pos < order.size())
                begin
                    if (t_owner[order[pos]] == q.owner_id)
                    begin
                        t_valid[order[pos]] = 1'b0;
                        take_at(pos);
                        any = 1;
                    end
                    else
                        pos++;
                end
                r.kind = KIND_REMOVE_ACK;
                r.status = any ? STAT_OK : STAT_NOT_FOUND;
                due_results.push_back(r);
            end
            default:
            begin
                e = q.elapsed_ms;
                for (int i = 0; e > 0 && i < order.size(); i++)
                begin
                    if (t_delta[order[i]] > e)
                    begin
                        t_delta[order[i]] -= e;
                        break;
                    end
                    e -= t_delta[order[i]];
                    t_delta[order[i]] = '0;
                end
                foreach (order[i])
                begin
                    if (t_delta[order[i]] != 0)
                        break;
                    expired.push_back(order[i]);
                end
                // expired entries are at the front, in list order
                foreach (expired[i])
                begin
                    rsp_t x;
                    s = expired[i];
                    x = blank();
                    x.kind = KIND_EXPIRY;
                    x.slot_out = 4'(s);
                    x.owner_out = t_owner[s];
                    x.tag_out = t_tag[s];
                    due_results.push_back(x);
                    pos = -1;
                    foreach (order[j])
                        if (pos < 0 && order[j] == s)
                            pos = j;
                    take_at(pos);
                    if (t_periodic[s])
                        put_slot(s);
                    else
                        t_valid[s] = 1'b0;
                end
                r.kind = KIND_NEXT;
                if (order.size() > 0)
                    r.next_timeout_ms = t_delta[order[0]];
                else
                    r.queue_empty = 1'b1;
                due_results.push_back(r);
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t w;
        if (!rst_n)
        begin
            for (int i = 0; i < NT; i++)
                t_valid[i] = 1'b0;
            order.delete();
            due_results.delete();
            errors = 0;
            expiries = 0;
            pending = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result transfer with nothing expected: %p", rsp);
                    errors++;
                end
                else
                begin
                    w = due_results.pop_front();
                    if (w.kind == KIND_EXPIRY)
                        expiries++;
                    if (rsp.kind !== w.kind)
                        begin $error("kind exp %0d got %0d", w.kind, rsp.kind); errors++; end
                    if (rsp.status !== w.status)
                        begin $error("status exp %0d got %0d", w.status, rsp.status); errors++; end
                    if (rsp.slot_out !== w.slot_out)
                        begin $error("slot_out exp %0d got %0d", w.slot_out, rsp.slot_out);
                              errors++; end
                    if (rsp.owner_out !== w.owner_out)
                        begin $error("owner_out exp %0d got %0d", w.owner_out, rsp.owner_out);
                              errors++; end
                    if (rsp.tag_out !== w.tag_out)
                        begin $error("tag_out exp %0d got %0d", w.tag_out, rsp.tag_out);
                              errors++; end
                    if (rsp.next_timeout_ms !== w.next_timeout_ms)
                        begin $error("next_timeout_ms exp %0d got %0d", w.next_timeout_ms,
                                     rsp.next_timeout_ms); errors++; end
                    if (rsp.queue_empty !== w.queue_empty)
                        begin $error("queue_empty exp %0d got %0d", w.queue_empty,
                                     rsp.queue_empty); errors++; end
                    if (rsp.last !== w.last)
                        begin $error("last exp %0d got %0d", w.last, rsp.last); errors++; end
                end
            end
            if (req_valid && req_ready)
                predict_request(req);
            pending = due_results.size();
        end
    end
endmodule

// ===== sim/delta_list_timer_queue_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_list_timer_queue_test
// Drives adds, removes, remove-all and ticks into the timer queue with random
// idling on both sides; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module delta_list_timer_queue_test;
    import dltq_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;
    int   errors;
    int   pending;
    int   expiries;
    int   idle_pct = 31;
    int   sent = 0;
    int   quiet = 0;
    logic [7:0] owners [4] = '{8'h00, 8'hff, 8'h5a, 8'h13};

    always #5 clk = ~clk;

    delta_list_timer_queue u_top (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    delta_list_timer_queue_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .errors(errors), .pending(pending), .expiries(expiries)
    );

    always @(posedge clk)
        rsp_ready <= ($urandom_range(99) >= idle_pct);

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send(req_t q);
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= q;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sent++;
    endtask

    function automatic req_t make_timer_cmd(logic [1:0] act, logic [7:0] own,
                                            logic [23:0] t, logic per);
        req_t q;
        q = '0;
        q.action = act;
        q.owner_id = own;
        q.user_tag = 16'($urandom);
        q.timeout_ms = t;
        q.periodic = per;
        q.elapsed_ms = t;
        return q;
    endfunction

    function automatic req_t random_cmd();
        req_t q;
        int r;
        q = req_t'({$urandom, $urandom});
        q.owner_id = owners[$urandom_range(3)];
        r = $urandom_range(99);
        if (r < 40)
        begin
            q.action = ACT_ADD;
            q.timeout_ms = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(60));
        end
        else if (r < 55)
            q.action = ACT_REMOVE;
        else if (r < 62)
            q.action = ACT_REMOVE_ALL;
        else
        begin
            q.action = ACT_TICK;
            q.elapsed_ms = ($urandom_range(19) == 0) ? 24'($urandom) : 24'($urandom_range(40));
        end
        return q;
    endfunction

    initial
    begin
        req_t q;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue, then fill past capacity with equal and extreme delays
        send(make_timer_cmd(ACT_TICK, 8'h00, 24'd5, 1'b0));
        send(make_timer_cmd(ACT_ADD, 8'hff, 24'hffffff, 1'b1));
        send(make_timer_cmd(ACT_ADD, 8'h00, 24'd0, 1'b1));
        for (int i = 0; i < 15; i++)
            send(make_timer_cmd(ACT_ADD, owners[i % 4], 24'd10, i[0]));
        q = make_timer_cmd(ACT_REMOVE, 8'h5a, 24'd0, 1'b0);
        q.use_slot = 1'b1;
        q.slot_in = 4'd15;
        send(q);
        q.slot_in = 4'd4;
        send(q);
        q.use_slot = 1'b0;
        send(q);
        send(make_timer_cmd(ACT_REMOVE_ALL, 8'h13, 24'd0, 1'b0));
        send(make_timer_cmd(ACT_REMOVE_ALL, 8'h77, 24'd0, 1'b0));
        send(make_timer_cmd(ACT_TICK, 8'h00, 24'd10, 1'b0));
        send(make_timer_cmd(ACT_TICK, 8'h00, 24'hffffff, 1'b0));

        // hold the sender until the queue drains
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        for (int i = 0; i < 250; i++)
        begin
            idle_pct = (i >= 100 && i < 160) ? 0 : 31;
            send(random_cmd());
        end
        send(make_timer_cmd(ACT_REMOVE_ALL, 8'h00, 24'd0, 1'b0));

        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("sent %0d requests covering add, remove, remove-all and tick", sent);
        $display("observed %0d timer expiries", expiries);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ===== delta_list_timer_queue.f =====
sv/dltq_pkg.sv
sv/dltq_front.sv
sv/dltq_engine.sv
sv/delta_list_timer_queue.sv
sim/delta_list_timer_queue_checker.sv
sim/delta_list_timer_queue_test.sv
